### rtl/prf_pkg.sv
// Shared types and constants for the FIFO/LRU page replacement block.
package prf_pkg;

    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_FRAMES_W = 6;
    localparam int SLOT_W       = 5;

    localparam logic [CFG_INDEX_W-1:0]  CFG_FRAMES   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0]  CFG_POLICY   = 8'd1;
    localparam logic [CFG_FRAMES_W-1:0] FRAMES_RESET = 6'd4;

    // Broadcast control from the sequencer to every frame cell.
    typedef struct packed {
        logic clear;    // drop all frames (start of a new sequence)
        logic update;   // apply the age/load step for the current item
        logic load;     // write the new page into the target frame
        logic age_all;  // age every valid frame, not only the younger ones
    } cell_ctl_t;

endpackage

### rtl/prf_cell.sv
// One page frame: stored page, valid bit, age rank and the hit priority link.
module prf_cell import prf_pkg::*; #(
    parameter int PAGE_BITS = 16,
    parameter int IDX_BITS  = 5,
    parameter int RANK_BITS = 5,
    parameter int CELL_IDX  = 0,
    parameter int MAX_SLOTS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctl_t            ctl,
    input  logic [IDX_BITS-1:0]  target,
    input  logic [RANK_BITS-1:0] limit,
    input  logic [PAGE_BITS-1:0] page_in,
    input  logic                 in_range,
    input  logic                 hit_in,
    output logic                 hit_out,
    output logic                 first,
    output logic                 valid,
    output logic [RANK_BITS-1:0] rank,
    output logic [PAGE_BITS-1:0] page
);

    localparam logic [RANK_BITS-1:0] RANK_MAX = RANK_BITS'(MAX_SLOTS - 1);
    localparam logic [IDX_BITS-1:0]  MY_IDX   = IDX_BITS'(CELL_IDX);

    logic                 valid_reg;
    logic [RANK_BITS-1:0] rank_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 sel;
    logic                 match;
    logic                 ages;

    assign sel   = (target == MY_IDX);
    assign match = valid_reg && in_range && (page_reg == page_in);
    // Lowest matching frame wins: pass the hit along the row.
    assign first   = match && !hit_in;
    assign hit_out = hit_in || match;
    assign ages    = valid_reg && (ctl.age_all || (rank_reg < limit)) && (rank_reg != RANK_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctl.update && sel && ctl.load) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.update) begin
            if (sel) begin
                rank_reg <= '0;
                if (ctl.load) begin
                    page_reg <= page_in;
                end
            end else if (ages) begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    assign valid = valid_reg;
    assign rank  = rank_reg;
    assign page  = page_reg;

endmodule

### rtl/prf_victim.sv
// Comparator tree that picks the in-range frame with the highest age rank.
module prf_victim import prf_pkg::*; #(
    parameter int MAX_SLOTS = 32,
    parameter int IDX_BITS  = 5,
    parameter int RANK_BITS = 5
) (
    input  logic [MAX_SLOTS-1:0]                mask,
    input  logic [MAX_SLOTS-1:0][RANK_BITS-1:0] ranks,
    output logic [IDX_BITS-1:0]                 victim
);

    localparam int LEAVES = 1 << IDX_BITS;
    localparam int NODES  = 2 * LEAVES - 1;

    logic                 node_en   [NODES];
    logic [RANK_BITS-1:0] node_rank [NODES];
    logic [IDX_BITS-1:0]  node_idx  [NODES];

    // Heap layout: left child covers lower indices, so ties keep the left one.
    always_comb begin
        for (int k = 0; k < NODES; k++) begin
            node_en[k]   = 1'b0;
            node_rank[k] = '0;
            node_idx[k]  = '0;
        end
        for (int i = 0; i < MAX_SLOTS; i++) begin
            node_en[LEAVES-1+i]   = mask[i];
            node_rank[LEAVES-1+i] = ranks[i];
            node_idx[LEAVES-1+i]  = IDX_BITS'(i);
        end
        for (int k = LEAVES - 2; k >= 0; k--) begin
            if (node_en[2*k+2] && (!node_en[2*k+1] || (node_rank[2*k+2] > node_rank[2*k+1])))
            begin
                node_en[k]   = 1'b1;
                node_rank[k] = node_rank[2*k+2];
                node_idx[k]  = node_idx[2*k+2];
            end else begin
                node_en[k]   = node_en[2*k+1];
                node_rank[k] = node_rank[2*k+1];
                node_idx[k]  = node_idx[2*k+1];
            end
        end
    end

    assign victim = node_idx[0];

endmodule

### rtl/page_replacement_fifo_lru.sv
// An item passes a lookup state, then an update state; its result is registered as the
// update commits, which waits while m_tready is low and a result is held. New items are
// taken only in idle or as one commits, as lookup and age/load step share the frame row.
// Reset: aresetn (synchronous, active low) empties all frames, clears the counters and
// the output, and restores 4 frames in use with FIFO policy.
module page_replacement_fifo_lru import prf_pkg::*; #(
    parameter int MAX_SLOTS  = 32,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // s_tdata: page
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0]               s_tdata,
    // s_tuser: new_sequence
    input  logic [0:0]                                   s_tuser,
    // m_tdata: slot, fault, evicted_valid, evicted_page, fault_total, hit_total
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [((SLOT_W+2+PAGE_BITS+2*COUNT_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [CFG_INDEX_W-1:0]                       cfg_index,
    input  logic [CFG_DATA_W-1:0]                        cfg_data
);

    localparam int IW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int RW        = IW;
    localparam int NW        = $clog2(MAX_SLOTS + 1);
    localparam int FW        = CFG_FRAMES_W + 1;
    localparam int M_TDATA_W = ((SLOT_W + 2 + PAGE_BITS + 2 * COUNT_BITS + 7) / 8) * 8;
    localparam logic [FW-1:0] MAX_N = FW'(MAX_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

    state_t                  state_reg, state_next;
    logic [CFG_FRAMES_W-1:0] frames_reg;
    logic                    policy_reg;
    logic [PAGE_BITS-1:0]    page_reg;
    logic [NW-1:0]           filled_reg;
    logic [COUNT_BITS-1:0]   fault_cnt_reg, fault_cnt_next;
    logic [COUNT_BITS-1:0]   hit_cnt_reg, hit_cnt_next;

    logic                    hit_reg;
    logic                    fill_reg;
    logic                    ev_valid_reg;
    logic                    age_all_reg;
    logic [IW-1:0]           target_reg;
    logic [RW-1:0]           limit_reg;

    logic                    m_tvalid_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic                    out_fault_reg;
    logic                    out_ev_valid_reg;
    logic [PAGE_BITS-1:0]    out_ev_page_reg;
    logic [COUNT_BITS-1:0]   out_fault_tot_reg;
    logic [COUNT_BITS-1:0]   out_hit_tot_reg;

    logic [NW-1:0]                   n_eff;
    logic [FW-1:0]                   frames_ext;
    logic [MAX_SLOTS-1:0]            in_range;
    logic [MAX_SLOTS:0]              hit_chain;
    logic [MAX_SLOTS-1:0]            first;
    logic [MAX_SLOTS-1:0]            cell_valid;
    logic [MAX_SLOTS-1:0][RW-1:0]    cell_rank;
    logic [PAGE_BITS-1:0]            cell_page [MAX_SLOTS];
    logic [IW-1:0]                   hit_idx;
    logic [RW-1:0]                   hit_rank;
    logic [IW-1:0]                   victim;
    logic                            out_free;
    logic                            accept;
    logic                            commit;
    cell_ctl_t                       ctl;

    // Effective frame count: zero acts as one, above the row size acts as the row size.
    assign frames_ext = {1'b0, frames_reg};
    always_comb begin
        if (frames_reg == '0) begin
            n_eff = NW'(1);
        end else if (frames_ext > MAX_N) begin
            n_eff = NW'(MAX_SLOTS);
        end else begin
            n_eff = NW'(frames_ext);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            in_range[i] = (NW'(i) < n_eff);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_UPD) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign ctl.clear   = accept && s_tuser[0];
    assign ctl.update  = commit && (!hit_reg || policy_reg);
    assign ctl.load    = !hit_reg;
    assign ctl.age_all = age_all_reg;

    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        prf_cell #(
            .PAGE_BITS (PAGE_BITS),
            .IDX_BITS  (IW),
            .RANK_BITS (RW),
            .CELL_IDX  (g),
            .MAX_SLOTS (MAX_SLOTS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .target   (target_reg),
            .limit    (limit_reg),
            .page_in  (page_reg),
            .in_range (in_range[g]),
            .hit_in   (hit_chain[g]),
            .hit_out  (hit_chain[g+1]),
            .first    (first[g]),
            .valid    (cell_valid[g]),
            .rank     (cell_rank[g]),
            .page     (cell_page[g])
        );
    end

    prf_victim #(
        .MAX_SLOTS (MAX_SLOTS),
        .IDX_BITS  (IW),
        .RANK_BITS (RW)
    ) u_victim (
        .mask   (in_range),
        .ranks  (cell_rank),
        .victim (victim)
    );

    // The hit vector is one-hot, so an OR of the selected terms encodes it.
    always_comb begin
        hit_idx  = '0;
        hit_rank = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (first[i]) begin
                hit_idx  = hit_idx | IW'(i);
                hit_rank = hit_rank | cell_rank[i];
            end
        end
    end

    always_comb begin
        fault_cnt_next = fault_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        if (hit_reg) begin
            if (hit_cnt_reg != '1) begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
        end else if (fault_cnt_reg != '1) begin
            fault_cnt_next = fault_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (accept) begin
                    state_next = ST_LOOK;
                end else if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            frames_reg    <= FRAMES_RESET;
            policy_reg    <= 1'b0;
            filled_reg    <= '0;
            fault_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_FRAMES: frames_reg <= cfg_data[CFG_FRAMES_W-1:0];
                    CFG_POLICY: policy_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (state_reg == ST_LOOK) begin
                hit_reg      <= hit_chain[MAX_SLOTS];
                fill_reg     <= 1'b0;
                ev_valid_reg <= 1'b0;
                if (hit_chain[MAX_SLOTS]) begin
                    target_reg  <= hit_idx;
                    limit_reg   <= hit_rank;
                    age_all_reg <= 1'b0;
                end else if (filled_reg < n_eff) begin
                    target_reg  <= IW'(filled_reg);
                    limit_reg   <= '0;
                    age_all_reg <= 1'b1;
                    fill_reg    <= 1'b1;
                end else begin
                    target_reg   <= victim;
                    limit_reg    <= '0;
                    age_all_reg  <= 1'b1;
                    ev_valid_reg <= cell_valid[victim];
                end
            end

            if (commit) begin
                m_tvalid_reg      <= 1'b1;
                out_slot_reg      <= SLOT_W'(target_reg);
                out_fault_reg     <= !hit_reg;
                out_ev_valid_reg  <= ev_valid_reg;
                out_ev_page_reg   <= ev_valid_reg ? cell_page[target_reg] : '0;
                out_fault_tot_reg <= fault_cnt_next;
                out_hit_tot_reg   <= hit_cnt_next;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // A new sequence clears after the finishing item has taken its counts.
            if (ctl.clear) begin
                filled_reg    <= '0;
                fault_cnt_reg <= '0;
                hit_cnt_reg   <= '0;
            end else if (commit) begin
                fault_cnt_reg <= fault_cnt_next;
                hit_cnt_reg   <= hit_cnt_next;
                if (fill_reg) begin
                    filled_reg <= filled_reg + 1'b1;
                end
            end

            if (accept) begin
                page_reg <= s_tdata[PAGE_BITS-1:0];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_hit_tot_reg, out_fault_tot_reg, out_ev_page_reg,
                                  out_ev_valid_reg, out_fault_reg, out_slot_reg});

endmodule
